FILE: rtl/mbet_pkg.sv
// ----------------------------------------------------------------------------
// mbet_pkg
// Shared constants, types and helpers of the escape-time pixel core.
// ----------------------------------------------------------------------------
package mbet_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 24;
  localparam int ITER_BITS  = 16;

  localparam int WORD_BITS  = 32;              // component word
  localparam int SIZE_BITS  = 13;              // image size register
  localparam int RAD_BITS   = 31;              // escape radius register
  localparam int IDX_BITS   = 3;               // config register index
  localparam int MAG_BITS   = COORD_BITS + WORD_BITS + 1; // |index * span|
  localparam int DCNT_BITS  = $clog2(MAG_BITS);
  localparam int SAT_BITS   = 72;              // width of saturation input

  localparam logic signed [WORD_BITS-1:0] RST_X_MIN = -32'sd33554432;
  localparam logic signed [WORD_BITS-1:0] RST_X_MAX = 32'sd16777216;
  localparam logic signed [WORD_BITS-1:0] RST_Y_MIN = -32'sd16777216;
  localparam logic signed [WORD_BITS-1:0] RST_Y_MAX = 32'sd16777216;
  localparam logic [SIZE_BITS-1:0]        RST_WIDTH = 13'd1024;
  localparam logic [SIZE_BITS-1:0]        RST_HEIGHT = 13'd1024;
  localparam logic [ITER_BITS-1:0]        RST_MAX_ITER = ITER_BITS'(256);
  localparam logic [RAD_BITS-1:0]         RST_RADIUS = 31'd33554432;

  typedef enum logic [IDX_BITS-1:0] {
    REG_X_MIN    = 3'd0,
    REG_X_MAX    = 3'd1,
    REG_Y_MIN    = 3'd2,
    REG_Y_MAX    = 3'd3,
    REG_WIDTH    = 3'd4,
    REG_HEIGHT   = 3'd5,
    REG_MAX_ITER = 3'd6,
    REG_RADIUS   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] x_min;
    logic signed [WORD_BITS-1:0] x_max;
    logic signed [WORD_BITS-1:0] y_min;
    logic signed [WORD_BITS-1:0] y_max;
    logic [SIZE_BITS-1:0]        image_width;
    logic [SIZE_BITS-1:0]        image_height;
    logic [ITER_BITS-1:0]        max_iter;
    logic [RAD_BITS-1:0]         escape_radius;
  } cfg_t;

  // Point c handed from the front to the back.
  typedef struct packed {
    logic signed [WORD_BITS-1:0] cre;
    logic signed [WORD_BITS-1:0] cim;
  } point_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_UPD
  } back_state_e;

  // Clamp a wide signed value to the component word.
  function automatic logic signed [WORD_BITS-1:0] sat_word(
    input logic signed [SAT_BITS-1:0] v
  );
    logic signed [SAT_BITS-1:0] hi;
    logic signed [SAT_BITS-1:0] lo;
    hi = SAT_BITS'(signed'({1'b0, {(WORD_BITS-1){1'b1}}}));
    lo = -hi - SAT_BITS'(1);
    if (v > hi) begin
      return hi[WORD_BITS-1:0];
    end else if (v < lo) begin
      return lo[WORD_BITS-1:0];
    end
    return v[WORD_BITS-1:0];
  endfunction

endpackage

FILE: rtl/mbet_if.sv
// ----------------------------------------------------------------------------
// mbet_if
// Valid/ready channels of the escape-time pixel core.
// ----------------------------------------------------------------------------
interface mbet_pix_if;
  logic                                valid;
  logic                                ready;
  logic [mbet_pkg::COORD_BITS-1:0]     pixel_row;
  logic [mbet_pkg::COORD_BITS-1:0]     pixel_col;
  modport source (output valid, output pixel_row, output pixel_col, input ready);
  modport sink   (input valid, input pixel_row, input pixel_col, output ready);
endinterface

interface mbet_cnt_if;
  logic                                valid;
  logic                                ready;
  logic [mbet_pkg::ITER_BITS-1:0]      iter_count;
  modport source (output valid, output iter_count, input ready);
  modport sink   (input valid, input iter_count, output ready);
endinterface

interface mbet_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [mbet_pkg::IDX_BITS-1:0]       index;
  logic [mbet_pkg::WORD_BITS-1:0]      data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/mbet_front.sv
// ----------------------------------------------------------------------------
// mbet_front
// Map a pixel to its point c: multiply, then bit-serial division by the size.
// ----------------------------------------------------------------------------
module mbet_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  mbet_pkg::cfg_t                  cfg_i,
  input  logic                            pix_valid_i,
  output logic                            pix_ready_o,
  input  logic [mbet_pkg::COORD_BITS-1:0] pixel_row_i,
  input  logic [mbet_pkg::COORD_BITS-1:0] pixel_col_i,
  output logic                            push_valid_o,
  input  logic                            push_ready_i,
  output mbet_pkg::point_t                push_data_o
);
  import mbet_pkg::*;

  front_state_e state_q, state_d;
  logic [DCNT_BITS-1:0] cnt_q, cnt_d;
  logic [MAG_BITS-1:0]  num_x_q, num_x_d, num_y_q, num_y_d;
  logic [SIZE_BITS:0]   rem_x_q, rem_x_d, rem_y_q, rem_y_d;
  logic                 neg_x_q, neg_x_d, neg_y_q, neg_y_d;

  logic [SIZE_BITS-1:0]        w, h;
  logic signed [WORD_BITS:0]   span_x, span_y;
  logic signed [MAG_BITS:0]    prod_x, prod_y;
  logic [SIZE_BITS:0]          sh_x, sh_y;
  logic                        qx, qy;
  logic signed [MAG_BITS+1:0]  qs_x, qs_y;
  logic signed [SAT_BITS-1:0]  sum_x, sum_y;

  assign w = (cfg_i.image_width  == '0) ? SIZE_BITS'(1) : cfg_i.image_width;
  assign h = (cfg_i.image_height == '0) ? SIZE_BITS'(1) : cfg_i.image_height;

  assign span_x = (WORD_BITS+1)'(cfg_i.x_max) - (WORD_BITS+1)'(cfg_i.x_min);
  assign span_y = (WORD_BITS+1)'(cfg_i.y_max) - (WORD_BITS+1)'(cfg_i.y_min);
  assign prod_x = (MAG_BITS+1)'(signed'({1'b0, pixel_col_i})) * (MAG_BITS+1)'(span_x);
  assign prod_y = (MAG_BITS+1)'(signed'({1'b0, pixel_row_i})) * (MAG_BITS+1)'(span_y);

  // One restoring-division step per cycle on both axes.
  assign sh_x = {rem_x_q[SIZE_BITS-1:0], num_x_q[MAG_BITS-1]};
  assign sh_y = {rem_y_q[SIZE_BITS-1:0], num_y_q[MAG_BITS-1]};
  assign qx   = (sh_x >= {1'b0, w});
  assign qy   = (sh_y >= {1'b0, h});

  assign qs_x  = neg_x_q ? -(MAG_BITS+2)'(num_x_q) : (MAG_BITS+2)'(num_x_q);
  assign qs_y  = neg_y_q ? -(MAG_BITS+2)'(num_y_q) : (MAG_BITS+2)'(num_y_q);
  assign sum_x = SAT_BITS'(cfg_i.x_min) + SAT_BITS'(qs_x);
  assign sum_y = SAT_BITS'(cfg_i.y_max) - SAT_BITS'(qs_y);

  always_comb begin
    state_d = state_q;
    case (state_q)
      FR_IDLE: if (pix_valid_i) state_d = FR_DIV;
      FR_DIV:  if (cnt_q == '0) state_d = FR_PUSH;
      FR_PUSH: if (push_ready_i) state_d = FR_IDLE;
      default: state_d = FR_IDLE;
    endcase
  end

  always_comb begin
    cnt_d   = cnt_q;
    num_x_d = num_x_q;
    num_y_d = num_y_q;
    rem_x_d = rem_x_q;
    rem_y_d = rem_y_q;
    neg_x_d = neg_x_q;
    neg_y_d = neg_y_q;
    case (state_q)
      FR_IDLE: begin
        neg_x_d = prod_x[MAG_BITS];
        neg_y_d = prod_y[MAG_BITS];
        num_x_d = prod_x[MAG_BITS] ? MAG_BITS'(-prod_x) : prod_x[MAG_BITS-1:0];
        num_y_d = prod_y[MAG_BITS] ? MAG_BITS'(-prod_y) : prod_y[MAG_BITS-1:0];
        rem_x_d = '0;
        rem_y_d = '0;
        cnt_d   = DCNT_BITS'(MAG_BITS - 1);
      end
      FR_DIV: begin
        rem_x_d = qx ? sh_x - {1'b0, w} : sh_x;
        rem_y_d = qy ? sh_y - {1'b0, h} : sh_y;
        num_x_d = {num_x_q[MAG_BITS-2:0], qx};
        num_y_d = {num_y_q[MAG_BITS-2:0], qy};
        cnt_d   = cnt_q - DCNT_BITS'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q   <= cnt_d;
    num_x_q <= num_x_d;
    num_y_q <= num_y_d;
    rem_x_q <= rem_x_d;
    rem_y_q <= rem_y_d;
    neg_x_q <= neg_x_d;
    neg_y_q <= neg_y_d;
  end

  assign pix_ready_o      = (state_q == FR_IDLE);
  assign push_valid_o     = (state_q == FR_PUSH);
  assign push_data_o.cre  = sat_word(sum_x);
  assign push_data_o.cim  = sat_word(sum_y);

endmodule

FILE: rtl/mbet_queue.sv
// ----------------------------------------------------------------------------
// mbet_queue
// Two-entry queue of mapped points between front and back.
// ----------------------------------------------------------------------------
module mbet_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  mbet_pkg::point_t push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output mbet_pkg::point_t pop_data_o
);
  import mbet_pkg::*;

  point_t     mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] fill_q, fill_d;
  logic       push, pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_ready_i && pop_valid_o;
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d   = push ? ~wr_q : wr_q;
    rd_d   = pop  ? ~rd_q : rd_q;
    fill_d = fill_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/mbet_back.sv
// ----------------------------------------------------------------------------
// mbet_back
// Iterate z = z*z + c: a product step, then an update-and-test step.
// ----------------------------------------------------------------------------
module mbet_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mbet_pkg::cfg_t                 cfg_i,
  input  logic                           pop_valid_i,
  output logic                           pop_ready_o,
  input  mbet_pkg::point_t               pop_data_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output logic [mbet_pkg::ITER_BITS-1:0] iter_count_o
);
  import mbet_pkg::*;

  back_state_e state_q, state_d;
  point_t                      c_q, c_d;
  logic signed [WORD_BITS-1:0] re_q, re_d, im_q, im_d;
  logic [ITER_BITS-1:0]        cnt_q, cnt_d;
  logic signed [2*WORD_BITS-1:0] rr_q, ii_q, ri_q;
  logic [2*RAD_BITS-1:0]       r2_q;
  logic                        res_valid_q, res_valid_d;
  logic [ITER_BITS-1:0]        res_cnt_q, res_cnt_d;

  logic [2*WORD_BITS-1:0]        mag2;
  logic                          escaped, done, load;
  logic signed [2*WORD_BITS-1:0] diff;
  logic signed [SAT_BITS-1:0]    nre_w, nim_w;

  // Squares are non-negative, so their sum is the squared magnitude.
  assign mag2    = $unsigned(rr_q) + $unsigned(ii_q);
  assign escaped = (mag2 > (2*WORD_BITS)'(r2_q));
  assign done    = escaped || (cnt_q == cfg_i.max_iter);
  assign load    = (state_q == BK_UPD) && done && (!res_valid_q || res_ready_i);

  assign diff  = rr_q - ii_q;
  assign nre_w = SAT_BITS'(diff >>> FRAC_BITS) + SAT_BITS'(c_q.cre);
  assign nim_w = SAT_BITS'(ri_q >>> (FRAC_BITS - 1)) + SAT_BITS'(c_q.cim);

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (pop_valid_i) state_d = BK_MUL;
      BK_MUL:  state_d = BK_UPD;
      BK_UPD: begin
        if (!done) begin
          state_d = BK_MUL;
        end else if (load) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    c_d   = c_q;
    re_d  = re_q;
    im_d  = im_q;
    cnt_d = cnt_q;
    res_cnt_d   = res_cnt_q;
    res_valid_d = res_valid_q && !res_ready_i;
    case (state_q)
      BK_IDLE: begin
        c_d   = pop_data_i;
        re_d  = '0;
        im_d  = '0;
        cnt_d = '0;
      end
      BK_UPD: begin
        if (!done) begin
          re_d  = sat_word(nre_w);
          im_d  = sat_word(nim_w);
          cnt_d = cnt_q + ITER_BITS'(1);
        end
      end
      default: ;
    endcase
    if (load) begin
      res_valid_d = 1'b1;
      res_cnt_d   = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q       <= c_d;
    re_q      <= re_d;
    im_q      <= im_d;
    cnt_q     <= cnt_d;
    res_cnt_q <= res_cnt_d;
    rr_q      <= re_q * re_q;
    ii_q      <= im_q * im_q;
    ri_q      <= re_q * im_q;
    r2_q      <= cfg_i.escape_radius * cfg_i.escape_radius;
  end

  assign pop_ready_o  = (state_q == BK_IDLE);
  assign res_valid_o  = res_valid_q;
  assign iter_count_o = res_cnt_q;

  a_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_UPD) |-> (cnt_q <= cfg_i.max_iter))
    else $error("iteration count passed the limit");

  a_upd_after_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_MUL) |=> (state_q == BK_UPD))
    else $error("product cycle not followed by update");

  a_load_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (res_valid_q && res_cnt_q == $past(cnt_q)))
    else $error("result register missed the finished count");

endmodule

FILE: rtl/mandelbrot_escape_time_pixel_core.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_core
// Escape-time iteration count for one pixel of a fixed-point view.
// ----------------------------------------------------------------------------
// Usage: write the view bounds, image size, iteration limit and escape radius
// on cfg_i while the core is idle (cfg_i.ready is always high). Send pixels on
// pix_i as row/column transactions; each yields one iter_count transaction on
// cnt_o, in order.
// Flow: the front maps the pixel with a bit-serial divider and offers the
// point to the queue when the division ends; it takes the next pixel in the
// cycle after that push. The back takes a point from the queue while idle,
// then tests z in a product state and an update/test state, iter_count + 1
// tests in all. The count loads into the output register once that register
// is free, and the next pop can follow in the cycle after the load. The
// back's loop sets the throughput.
// The front, a two-entry queue and the back stall independently, so a new
// pixel is mapped while earlier ones iterate.
// Reset clears all control state and loads the default view (-2..1, -1..1,
// 1024x1024, limit 256, radius 2). When cnt_o stalls the finished count holds
// in the output register, the back holds its last item, and pix_i drops ready
// once the queue and the front fill.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  mbet_cfg_if.sink        cfg_i,
  mbet_pix_if.sink        pix_i,
  mbet_cnt_if.source      cnt_o
);
  import mbet_pkg::*;

  cfg_t   cfg_q, cfg_d;
  logic   push_valid, push_ready, pop_valid, pop_ready;
  point_t push_data, pop_data;

  // Configuration registers: always ready, written on a completed transaction.
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (reg_idx_e'(cfg_i.index))
        REG_X_MIN:    cfg_d.x_min         = cfg_i.data;
        REG_X_MAX:    cfg_d.x_max         = cfg_i.data;
        REG_Y_MIN:    cfg_d.y_min         = cfg_i.data;
        REG_Y_MAX:    cfg_d.y_max         = cfg_i.data;
        REG_WIDTH:    cfg_d.image_width   = cfg_i.data[SIZE_BITS-1:0];
        REG_HEIGHT:   cfg_d.image_height  = cfg_i.data[SIZE_BITS-1:0];
        REG_MAX_ITER: cfg_d.max_iter      = cfg_i.data[ITER_BITS-1:0];
        REG_RADIUS:   cfg_d.escape_radius = cfg_i.data[RAD_BITS-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_min         <= RST_X_MIN;
      cfg_q.x_max         <= RST_X_MAX;
      cfg_q.y_min         <= RST_Y_MIN;
      cfg_q.y_max         <= RST_Y_MAX;
      cfg_q.image_width   <= RST_WIDTH;
      cfg_q.image_height  <= RST_HEIGHT;
      cfg_q.max_iter      <= RST_MAX_ITER;
      cfg_q.escape_radius <= RST_RADIUS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: accept pixels and map them to points.
  mbet_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .pix_valid_i  (pix_i.valid),
    .pix_ready_o  (pix_i.ready),
    .pixel_row_i  (pix_i.pixel_row),
    .pixel_col_i  (pix_i.pixel_col),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // Queue: decouple mapping from iteration.
  mbet_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Back: iterate and hold the count in the output register.
  mbet_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_data_i   (pop_data),
    .res_valid_o  (cnt_o.valid),
    .res_ready_i  (cnt_o.ready),
    .iter_count_o (cnt_o.iter_count)
  );

endmodule
